FILE: sv/vab_pkg.sv
// Shared types, constants and helpers for the voxel box body step unit.
package vab_pkg;

  localparam int WORLD_X_DEF = 16;
  localparam int WORLD_Y_DEF = 64;
  localparam int WORLD_Z_DEF = 16;

  localparam int POS_W = 20;
  localparam int VEL_W = 16;
  localparam int DT_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  // Wide working width for positions, bounds and products.
  localparam int WIDE_W = 34;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_PLACE = 2'd1,
    FUNC_SETV  = 2'd2,
    FUNC_STEP  = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRAVITY  = 3'd0,
    REG_FRICTION = 3'd1,
    REG_HALF_W   = 3'd2,
    REG_HEIGHT   = 3'd3,
    REG_PROBE    = 3'd4
  } reg_idx_t;

  // Request from the sequencer to the box scanner.
  typedef struct packed {
    logic                     go;
    logic signed [WIDE_W-1:0] x;
    logic signed [WIDE_W-1:0] y;
    logic signed [WIDE_W-1:0] z;
  } box_req_t;

  typedef struct packed {
    logic done;
    logic hit;
  } box_rsp_t;

  function automatic logic signed [WIDE_W-1:0] sat_w(input logic signed [WIDE_W-1:0] v,
                                                      input int w);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = (WIDE_W'(1) <<< (w - 1)) - WIDE_W'(1);
    lo = -hi - WIDE_W'(1);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

endpackage

FILE: sv/vab_ram.sv
// Generic single port RAM with registered read.
module vab_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

FILE: sv/vab_box_scan.sv
// Box scanner: walks the cells a box covers and reports whether any is solid.
module vab_box_scan #(
  parameter int WORLD_X = vab_pkg::WORLD_X_DEF,
  parameter int WORLD_Y = vab_pkg::WORLD_Y_DEF,
  parameter int WORLD_Z = vab_pkg::WORLD_Z_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  vab_pkg::box_req_t req,
  input  logic [10:0]       half_w,
  input  logic [11:0]       height,
  input  logic              clr_busy,
  input  logic              wr_en,
  input  logic [$clog2(WORLD_X)+$clog2(WORLD_Y)+$clog2(WORLD_Z)-1:0] wr_addr,
  input  logic              wr_data,
  output vab_pkg::box_rsp_t rsp
);
  import vab_pkg::*;

  localparam int XW = $clog2(WORLD_X);
  localparam int YW = $clog2(WORLD_Y);
  localparam int ZW = $clog2(WORLD_Z);
  localparam int AW = XW + YW + ZW;

  typedef enum logic [1:0] {S_IDLE, S_BOUND, S_SCAN, S_LAST} scan_state_t;

  scan_state_t state_r;
  logic signed [WIDE_W-1:0] x0_r, x1_r, y0_r, y1_r, z0_r, z1_r;
  logic [XW-1:0] a_r;
  logic [YW-1:0] b_r, b0_r;
  logic [ZW-1:0] c_r, c0_r;
  logic [XW-1:0] a1_r;
  logic [YW-1:0] b1_r;
  logic [ZW-1:0] c1_r;
  logic hit_r, done_r, rd_valid_r;

  logic signed [WIDE_W-1:0] xlo, xhi, ylo, yhi, zlo, zhi;
  logic last_cell;
  logic [AW-1:0] addr;
  logic rdata;

  // Floor shift of a two's complement value is an arithmetic shift.
  assign xlo = (req.x - $signed(WIDE_W'(half_w))) >>> 8;
  assign xhi = (req.x + $signed(WIDE_W'(half_w))) >>> 8;
  assign zlo = (req.z - $signed(WIDE_W'(half_w))) >>> 8;
  assign zhi = (req.z + $signed(WIDE_W'(half_w))) >>> 8;
  assign ylo = req.y >>> 8;
  assign yhi = (req.y + $signed(WIDE_W'(height))) >>> 8;

  assign last_cell = (a_r == a1_r) && (b_r == b1_r) && (c_r == c1_r);
  assign addr = wr_en ? wr_addr : {a_r, b_r, c_r};

  vab_ram #(.WIDTH(1), .DEPTH(1 << AW)) u_map (
    .clk  (clk),
    .we   (wr_en),
    .addr (addr),
    .wdata(wr_data),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r <= 1'b0;
      hit_r <= 1'b0;
      rd_valid_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      rd_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (req.go && !clr_busy) begin
            x0_r <= (xlo < 0) ? '0 : xlo;
            x1_r <= (xhi > WIDE_W'(WORLD_X - 1)) ? WIDE_W'(WORLD_X - 1) : xhi;
            y0_r <= (ylo < 0) ? '0 : ylo;
            y1_r <= (yhi > WIDE_W'(WORLD_Y - 1)) ? WIDE_W'(WORLD_Y - 1) : yhi;
            z0_r <= (zlo < 0) ? '0 : zlo;
            z1_r <= (zhi > WIDE_W'(WORLD_Z - 1)) ? WIDE_W'(WORLD_Z - 1) : zhi;
            state_r <= S_BOUND;
          end
        end
        S_BOUND: begin
          a_r <= x0_r[XW-1:0];
          a1_r <= x1_r[XW-1:0];
          b_r <= y0_r[YW-1:0];
          b0_r <= y0_r[YW-1:0];
          b1_r <= y1_r[YW-1:0];
          c_r <= z0_r[ZW-1:0];
          c0_r <= z0_r[ZW-1:0];
          c1_r <= z1_r[ZW-1:0];
          hit_r <= 1'b0;
          if ((x0_r > x1_r) || (y0_r > y1_r) || (z0_r > z1_r)) begin
            done_r <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          // One cell read a cycle; the read data lands in the cycle after the read.
          rd_valid_r <= 1'b1;
          if (rd_valid_r && rdata) hit_r <= 1'b1;
          if (last_cell) begin
            state_r <= S_LAST;
          end else if (c_r != c1_r) begin
            c_r <= c_r + ZW'(1);
          end else begin
            c_r <= c0_r;
            if (b_r != b1_r) begin
              b_r <= b_r + YW'(1);
            end else begin
              b_r <= b0_r;
              a_r <= a_r + XW'(1);
            end
          end
        end
        S_LAST: begin
          if (rd_valid_r && rdata) hit_r <= 1'b1;
          done_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.hit = hit_r;
endmodule

FILE: sv/voxel_aabb_body_step_unit.sv
// Top level: body state, shared multiplier sequencer and map clearing.
// One word is taken while busy is low; its result appears on out_valid for one
// cycle and cannot be stalled, and busy stays high through that cycle. Every box
// test reads the covered map cells one a cycle through the single map RAM port,
// and all products go through one multiplier. A cell write, place or set velocity
// runs one box test, the ground probe; a step runs four box tests (the Y, X and Z
// moves, then the ground probe), each covering up to 12 cells with the default box
// size. A box test whose box lies wholly outside the map finishes without reading
// any cell. After reset the map is cleared one cell a cycle, all 2^(XW+YW+ZW)
// cells where each width is the bits of one cell index (16384 by default), with
// busy held high.
module voxel_aabb_body_step_unit #(
  parameter int WORLD_X = vab_pkg::WORLD_X_DEF,
  parameter int WORLD_Y = vab_pkg::WORLD_Y_DEF,
  parameter int WORLD_Z = vab_pkg::WORLD_Z_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_func,
  input  logic [3:0]                        in_cell_x,
  input  logic [5:0]                        in_cell_y,
  input  logic [3:0]                        in_cell_z,
  input  logic                              in_cell_solid,
  input  logic signed [19:0]                in_place_x,
  input  logic signed [19:0]                in_place_y,
  input  logic signed [19:0]                in_place_z,
  input  logic signed [15:0]                in_new_vel_x,
  input  logic signed [15:0]                in_new_vel_y,
  input  logic signed [15:0]                in_new_vel_z,
  input  logic [15:0]                       in_time_step,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [vab_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [vab_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                              out_valid,
  output logic signed [19:0]                out_body_x,
  output logic signed [19:0]                out_body_y,
  output logic signed [19:0]                out_body_z,
  output logic signed [15:0]                out_body_vx,
  output logic signed [15:0]                out_body_vy,
  output logic signed [15:0]                out_body_vz,
  output logic                              out_landed,
  output logic                              out_ground_probe
);
  import vab_pkg::*;

  localparam int XW = $clog2(WORLD_X);
  localparam int YW = $clog2(WORLD_Y);
  localparam int ZW = $clog2(WORLD_Z);
  localparam int AW = XW + YW + ZW;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_GRAV, S_VYMUL, S_YTEST, S_YWAIT, S_XMUL, S_XTEST,
    S_XWAIT, S_ZMUL, S_ZTEST, S_ZWAIT, S_FRICX, S_FRICZ, S_PROBE, S_PWAIT
  } state_t;

  state_t state_r;
  logic [AW:0] clr_cnt_r;
  logic signed [WIDE_W-1:0] px_r, py_r, pz_r, vx_r, vy_r, vz_r, n_r;
  logic ground_r;
  logic [DT_W-1:0] dt_r;
  logic signed [15:0] grav_r;
  logic [8:0] fric_r, probe_r;
  logic [10:0] half_w_r;
  logic [11:0] height_r;
  logic out_valid_r;
  box_req_t req_r;
  box_rsp_t rsp;

  // Shared multiplier: signed 17 bit by signed 17 bit.
  logic signed [16:0] mul_a, mul_b;
  logic signed [WIDE_W-1:0] prod;
  logic signed [WIDE_W-1:0] prod16;
  logic signed [WIDE_W-1:0] prod8;

  logic wr_en;
  logic [AW-1:0] wr_addr;
  logic wr_data;
  logic in_map;

  always_comb begin
    mul_a = 17'(vy_r);
    mul_b = {1'b0, dt_r};
    case (state_r)
      S_GRAV:  mul_a = 17'(grav_r);
      S_VYMUL: mul_a = 17'(vy_r);
      S_XMUL:  mul_a = 17'(vx_r);
      S_ZMUL:  mul_a = 17'(vz_r);
      S_FRICX: begin
        mul_a = 17'(vx_r);
        mul_b = {8'd0, fric_r};
      end
      S_FRICZ: begin
        mul_a = 17'(vz_r);
        mul_b = {8'd0, fric_r};
      end
      default: ;
    endcase
  end

  assign prod = WIDE_W'(mul_a * mul_b);
  assign prod16 = prod >>> 16;
  assign prod8 = prod >>> 8;

  assign in_map = (32'(in_cell_x) < WORLD_X) && (32'(in_cell_y) < WORLD_Y) &&
                  (32'(in_cell_z) < WORLD_Z);
  assign wr_en = (state_r == S_CLEAR) ||
                 (state_r == S_IDLE && start && !out_valid_r && in_func == FUNC_WRITE &&
                  in_map);
  assign wr_addr = (state_r == S_CLEAR) ? clr_cnt_r[AW-1:0] :
                   {XW'(in_cell_x), YW'(in_cell_y), ZW'(in_cell_z)};
  assign wr_data = (state_r == S_CLEAR) ? 1'b0 : in_cell_solid;

  vab_box_scan #(.WORLD_X(WORLD_X), .WORLD_Y(WORLD_Y), .WORLD_Z(WORLD_Z)) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req_r),
    .half_w  (half_w_r),
    .height  (height_r),
    .clr_busy(state_r == S_CLEAR),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rsp     (rsp)
  );

  assign busy = (state_r != S_IDLE) || out_valid_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_cnt_r <= '0;
      px_r <= '0;
      py_r <= '0;
      pz_r <= '0;
      vx_r <= '0;
      vy_r <= '0;
      vz_r <= '0;
      ground_r <= 1'b0;
      grav_r <= -16'sd5120;
      fric_r <= 9'd205;
      half_w_r <= 11'd77;
      height_r <= 12'd461;
      probe_r <= 9'd13;
      out_valid_r <= 1'b0;
      req_r.go <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      req_r.go <= 1'b0;
      if (cfg_valid) begin
        case (cfg_index)
          REG_GRAVITY:  grav_r <= cfg_data;
          REG_FRICTION: fric_r <= cfg_data[8:0];
          REG_HALF_W:   half_w_r <= cfg_data[10:0];
          REG_HEIGHT:   height_r <= cfg_data[11:0];
          REG_PROBE:    probe_r <= cfg_data[8:0];
          default: ;
        endcase
      end
      case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + (AW + 1)'(1);
          if (clr_cnt_r == (AW + 1)'((1 << AW) - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (start && !out_valid_r) begin
            dt_r <= in_time_step;
            case (in_func)
              FUNC_WRITE: state_r <= S_PROBE;
              FUNC_PLACE: begin
                px_r <= WIDE_W'(in_place_x);
                py_r <= WIDE_W'(in_place_y);
                pz_r <= WIDE_W'(in_place_z);
                vx_r <= '0;
                vy_r <= '0;
                vz_r <= '0;
                ground_r <= 1'b0;
                state_r <= S_PROBE;
              end
              FUNC_SETV: begin
                vx_r <= WIDE_W'(in_new_vel_x);
                vy_r <= WIDE_W'(in_new_vel_y);
                vz_r <= WIDE_W'(in_new_vel_z);
                state_r <= S_PROBE;
              end
              default: state_r <= S_GRAV;
            endcase
          end
        end
        S_GRAV: begin
          vy_r <= sat_w(vy_r + prod16, VEL_W);
          state_r <= S_VYMUL;
        end
        S_VYMUL: begin
          n_r <= sat_w(py_r + prod16, POS_W);
          state_r <= S_YTEST;
        end
        S_YTEST: begin
          req_r.go <= 1'b1;
          req_r.x <= px_r;
          req_r.y <= n_r;
          req_r.z <= pz_r;
          state_r <= S_YWAIT;
        end
        S_YWAIT: begin
          if (rsp.done) begin
            if (!rsp.hit) begin
              py_r <= n_r;
              ground_r <= 1'b0;
            end else begin
              if (vy_r < 0) ground_r <= 1'b1;
              vy_r <= '0;
            end
            state_r <= S_XMUL;
          end
        end
        S_XMUL: begin
          n_r <= sat_w(px_r + prod16, POS_W);
          state_r <= S_XTEST;
        end
        S_XTEST: begin
          req_r.go <= 1'b1;
          req_r.x <= n_r;
          req_r.y <= py_r;
          req_r.z <= pz_r;
          state_r <= S_XWAIT;
        end
        S_XWAIT: begin
          if (rsp.done) begin
            if (!rsp.hit) px_r <= n_r;
            else vx_r <= '0;
            state_r <= S_ZMUL;
          end
        end
        S_ZMUL: begin
          n_r <= sat_w(pz_r + prod16, POS_W);
          state_r <= S_ZTEST;
        end
        S_ZTEST: begin
          req_r.go <= 1'b1;
          req_r.x <= px_r;
          req_r.y <= py_r;
          req_r.z <= n_r;
          state_r <= S_ZWAIT;
        end
        S_ZWAIT: begin
          if (rsp.done) begin
            if (!rsp.hit) pz_r <= n_r;
            else vz_r <= '0;
            state_r <= S_FRICX;
          end
        end
        S_FRICX: begin
          vx_r <= sat_w(prod8, VEL_W);
          state_r <= S_FRICZ;
        end
        S_FRICZ: begin
          vz_r <= sat_w(prod8, VEL_W);
          state_r <= S_PROBE;
        end
        S_PROBE: begin
          req_r.go <= 1'b1;
          req_r.x <= px_r;
          req_r.y <= py_r - WIDE_W'(probe_r);
          req_r.z <= pz_r;
          state_r <= S_PWAIT;
        end
        S_PWAIT: begin
          if (rsp.done) begin
            out_valid_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_PWAIT && rsp.done) begin
      out_body_x <= px_r[19:0];
      out_body_y <= py_r[19:0];
      out_body_z <= pz_r[19:0];
      out_body_vx <= vx_r[15:0];
      out_body_vy <= vy_r[15:0];
      out_body_vz <= vz_r[15:0];
      out_landed <= ground_r;
      out_ground_probe <= rsp.hit;
    end
  end

  assign out_valid = out_valid_r;
endmodule

FILE: sv/vab_checker.sv
// Port level checker for the voxel box body step unit, bound to the top level.
module vab_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic cfg_ready
);
  logic launched_r;

  always_ff @(posedge clk) begin
    if (!rst_n) launched_r <= 1'b0;
    else if (start && !busy) launched_r <= 1'b1;
    else if (out_valid) launched_r <= 1'b0;
  end

  // A result word only follows an accepted item.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> launched_r) else $error("result without an accepted item");

  // The block stays busy while a result is being delivered.
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("not busy while result shown");

  // An accepted item makes the block busy in the next cycle.
  a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("not busy after accept");

  // Strobe lasts one cycle.
  a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready) else $error("configuration port not ready");
endmodule

bind voxel_aabb_body_step_unit vab_checker u_vab_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .out_valid(out_valid),
  .cfg_ready(cfg_ready)
);

FILE: bench/voxel_aabb_body_step_unit_tb.sv
// Self-checking bench for the voxel box body step unit: drives words, predicts state, checks results.
module voxel_aabb_body_step_unit_tb;
  import vab_pkg::*;

  localparam int WX = WORLD_X_DEF;
  localparam int WY = WORLD_Y_DEF;
  localparam int WZ = WORLD_Z_DEF;

  typedef struct {
    logic signed [19:0] bx, by, bz;
    logic signed [15:0] vx, vy, vz;
    logic               landed, probe;
  } body_state_t;

  class body_scoreboard;
    bit                 cells [WX*WY*WZ];
    longint             px, py, pz, vx, vy, vz;
    bit                 grounded;
    longint             grav, fric, hw, hgt, drop;
    body_state_t        pending [$];
    int                 errors;

    function void clear();
      foreach (cells[i]) cells[i] = 0;
      px = 0; py = 0; pz = 0; vx = 0; vy = 0; vz = 0; grounded = 0;
      grav = -5120; fric = 205; hw = 77; hgt = 461; drop = 13;
      errors = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [15:0] d);
      case (idx)
        REG_GRAVITY:  grav = longint'($signed(d));
        REG_FRICTION: fric = longint'(d[8:0]);
        REG_HALF_W:   hw = longint'(d[10:0]);
        REG_HEIGHT:   hgt = longint'(d[11:0]);
        REG_PROBE:    drop = longint'(d[8:0]);
        default: ;
      endcase
    endfunction

    // Arithmetic shift of a longint already floors toward minus infinity.
    function longint clip(longint v, int w);
      longint hi, lo;
      hi = (longint'(1) << (w - 1)) - 1;
      lo = -hi - 1;
      return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    function bit overlaps(longint x, longint y, longint z);
      longint x0, x1, y0, y1, z0, z1;
      x0 = (x - hw) >>> 8; x1 = (x + hw) >>> 8;
      y0 = y >>> 8;        y1 = (y + hgt) >>> 8;
      z0 = (z - hw) >>> 8; z1 = (z + hw) >>> 8;
      if (x0 < 0) x0 = 0;
      if (y0 < 0) y0 = 0;
      if (z0 < 0) z0 = 0;
      if (x1 > WX - 1) x1 = WX - 1;
      if (y1 > WY - 1) y1 = WY - 1;
      if (z1 > WZ - 1) z1 = WZ - 1;
      for (longint a = x0; a <= x1; a++)
        for (longint b = y0; b <= y1; b++)
          for (longint c = z0; c <= z1; c++)
            if (cells[(a * WY + b) * WZ + c]) return 1;
      return 0;
    endfunction

    function void note_word(func_t f, logic [3:0] cx, logic [5:0] cy, logic [3:0] cz,
                            logic sol, logic signed [19:0] qx, logic signed [19:0] qy,
                            logic signed [19:0] qz, logic signed [15:0] nx,
                            logic signed [15:0] ny, logic signed [15:0] nz,
                            logic [15:0] dt_in);
      longint dt, n;
      body_state_t e;
      case (f)
        FUNC_WRITE: cells[(int'(cx) * WY + int'(cy)) * WZ + int'(cz)] = sol;
        FUNC_PLACE: begin
          px = longint'(qx); py = longint'(qy); pz = longint'(qz);
          vx = 0; vy = 0; vz = 0; grounded = 0;
        end
        FUNC_SETV: begin
          vx = longint'(nx); vy = longint'(ny); vz = longint'(nz);
        end
        default: begin
          dt = longint'(dt_in);
          vy = clip(vy + ((grav * dt) >>> 16), 16);
          n = clip(py + ((vy * dt) >>> 16), 20);
          if (!overlaps(px, n, pz)) begin
            py = n; grounded = 0;
          end else begin
            if (vy < 0) grounded = 1;
            vy = 0;
          end
          n = clip(px + ((vx * dt) >>> 16), 20);
          if (!overlaps(n, py, pz)) px = n; else vx = 0;
          n = clip(pz + ((vz * dt) >>> 16), 20);
          if (!overlaps(px, py, n)) pz = n; else vz = 0;
          vx = clip((vx * fric) >>> 8, 16);
          vz = clip((vz * fric) >>> 8, 16);
        end
      endcase
      e.bx = px[19:0]; e.by = py[19:0]; e.bz = pz[19:0];
      e.vx = vx[15:0]; e.vy = vy[15:0]; e.vz = vz[15:0];
      e.landed = grounded;
      e.probe = overlaps(px, py - drop, pz);
      pending.push_back(e);
    endfunction

    function void check_word(body_state_t got);
      body_state_t e;
      if (pending.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.bx !== e.bx) begin $error("body_x exp %0d got %0d", e.bx, got.bx); errors++; end
      if (got.by !== e.by) begin $error("body_y exp %0d got %0d", e.by, got.by); errors++; end
      if (got.bz !== e.bz) begin $error("body_z exp %0d got %0d", e.bz, got.bz); errors++; end
      if (got.vx !== e.vx) begin $error("body_vx exp %0d got %0d", e.vx, got.vx); errors++; end
      if (got.vy !== e.vy) begin $error("body_vy exp %0d got %0d", e.vy, got.vy); errors++; end
      if (got.vz !== e.vz) begin $error("body_vz exp %0d got %0d", e.vz, got.vz); errors++; end
      if (got.landed !== e.landed) begin
        $error("landed exp %0b got %0b", e.landed, got.landed); errors++;
      end
      if (got.probe !== e.probe) begin
        $error("ground_probe exp %0b got %0b", e.probe, got.probe); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic [1:0] in_func = '0;
  logic [3:0] in_cell_x = '0;
  logic [5:0] in_cell_y = '0;
  logic [3:0] in_cell_z = '0;
  logic in_cell_solid = 0;
  logic signed [19:0] in_place_x = '0, in_place_y = '0, in_place_z = '0;
  logic signed [15:0] in_new_vel_x = '0, in_new_vel_y = '0, in_new_vel_z = '0;
  logic [15:0] in_time_step = '0;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic out_valid;
  logic signed [19:0] out_body_x, out_body_y, out_body_z;
  logic signed [15:0] out_body_vx, out_body_vy, out_body_vz;
  logic out_landed, out_ground_probe;

  body_scoreboard board;

  voxel_aabb_body_step_unit DUT (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    body_state_t got;
    if (rst_n && out_valid) begin
      got.bx = out_body_x; got.by = out_body_y; got.bz = out_body_z;
      got.vx = out_body_vx; got.vy = out_body_vy; got.vz = out_body_vz;
      got.landed = out_landed; got.probe = out_ground_probe;
      board.check_word(got);
    end
  end

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    repeat (n) @(posedge clk);
  endtask

  // Holds start high until the block takes the word, then notes it.
  task automatic send_word(func_t f, logic [3:0] cx, logic [5:0] cy, logic [3:0] cz,
                           logic sol, logic signed [19:0] qx, logic signed [19:0] qy,
                           logic signed [19:0] qz, logic signed [15:0] nx,
                           logic signed [15:0] ny, logic signed [15:0] nz,
                           logic [15:0] dt);
    start <= 1; in_func <= f;
    in_cell_x <= cx; in_cell_y <= cy; in_cell_z <= cz; in_cell_solid <= sol;
    in_place_x <= qx; in_place_y <= qy; in_place_z <= qz;
    in_new_vel_x <= nx; in_new_vel_y <= ny; in_new_vel_z <= nz;
    in_time_step <= dt;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_word(f, cx, cy, cz, sol, qx, qy, qz, nx, ny, nz, dt);
    start <= 0;
    @(posedge clk);
    idle_gap();
  endtask

  task automatic put_cell(int x, int y, int z, bit s);
    send_word(FUNC_WRITE, 4'(x), 6'(y), 4'(z), s, 0, 0, 0, 0, 0, 0, 0);
  endtask
  task automatic place(int x, int y, int z);
    send_word(FUNC_PLACE, 0, 0, 0, 0, 20'(x), 20'(y), 20'(z), 0, 0, 0, 0);
  endtask
  task automatic set_vel(int x, int y, int z);
    send_word(FUNC_SETV, 0, 0, 0, 0, 0, 0, 0, 16'(x), 16'(y), 16'(z), 0);
  endtask
  task automatic step(int dt);
    send_word(FUNC_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 16'(dt));
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, int d);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= 16'(d);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_reg(idx, 16'(d));
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic random_word(bit near_floor);
    int k;
    k = $urandom_range(0, 9);
    if (k < 2)
      send_word(FUNC_WRITE, 4'($urandom), 6'(near_floor ? $urandom_range(0, 6) : $urandom),
                4'($urandom), 1'($urandom), 20'($urandom), 20'($urandom), 20'($urandom),
                16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    else if (k < 3)
      if (near_floor)
        place($urandom_range(0, 16 * 256), $urandom_range(0, 8 * 256), $urandom_range(0, 16 * 256));
      else
        send_word(FUNC_PLACE, 0, 0, 0, 0, 20'($urandom), 20'($urandom), 20'($urandom),
                  0, 0, 0, 0);
    else if (k < 5)
      if (near_floor)
        set_vel($signed($urandom_range(0, 4096)) - 2048, $signed($urandom_range(0, 4096)) - 2048,
                $signed($urandom_range(0, 4096)) - 2048);
      else
        send_word(FUNC_SETV, 0, 0, 0, 0, 0, 0, 0, 16'($urandom), 16'($urandom),
                  16'($urandom), 0);
    else
      step(near_floor && $urandom_range(0, 3) != 0 ? $urandom_range(0, 2000) : $urandom);
  endtask

  initial begin
    board = new();
    board.clear();
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    write_reg(REG_GRAVITY, 16'hEC00);
    // Floor layer and a wall, then a body dropping onto the floor.
    for (int x = 0; x < 4; x++) put_cell(x, 0, 1, 1);
    put_cell(2, 1, 1, 1);
    put_cell(15, 63, 15, 1);
    put_cell(15, 63, 15, 0);
    place(256 + 128, 3 * 256, 256 + 128);
    repeat (4) step(16'hFFFF);
    set_vel(32767, 0, -32768);
    step(6553);
    set_vel(-32768, 32767, 32767);
    step(0);
    place(-524288, -524288, 524287);
    set_vel(-32768, -32768, -32768);
    step(16'hFFFF);
    place(524287, 524287, -524288);
    step(16'hFFFF);
    place(0, 0, 0);
    step(100);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_FRICTION, 256); write_reg(REG_HALF_W, 0);
          write_reg(REG_HEIGHT, 0); write_reg(REG_PROBE, 0); write_reg(REG_GRAVITY, 16'h7FFF);
        end
        1: begin
          write_reg(REG_FRICTION, 0); write_reg(REG_HALF_W, 1024);
          write_reg(REG_HEIGHT, 2048); write_reg(REG_PROBE, 256);
          write_reg(REG_GRAVITY, 16'h8000);
        end
        2: begin
          write_reg(REG_FRICTION, 511); write_reg(REG_HALF_W, 2047);
          write_reg(REG_HEIGHT, 4095); write_reg(REG_PROBE, 511);
        end
        3: begin
          write_reg(REG_FRICTION, $urandom_range(0, 256));
          write_reg(REG_HALF_W, $urandom_range(0, 200));
          write_reg(REG_HEIGHT, $urandom_range(0, 600));
          write_reg(REG_PROBE, $urandom_range(0, 256));
          write_reg(REG_GRAVITY, $signed($urandom_range(0, 20000)) - 10000);
        end
        default: begin
          write_reg(REG_GRAVITY, -5120); write_reg(REG_FRICTION, 205);
          write_reg(REG_HALF_W, 77); write_reg(REG_HEIGHT, 461); write_reg(REG_PROBE, 13);
        end
      endcase
      for (int i = 0; i < 215; i++) begin
        random_word($urandom_range(0, 4) != 0);
        if (i == 100) while (board.pending.size() != 0) @(posedge clk);
      end
      drain();
    end

    if (board.errors == 0 && board.pending.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #1000000000;
    $display("DONE: errors detected");
    $finish;
  end
endmodule
